>>> sv/url_dec_pkg.sv
package url_dec_pkg;

   // Decoder phases.
   localparam logic [1:0] PH_USUAL  = 2'd0;
   localparam logic [1:0] PH_FIRST  = 2'd1;
   localparam logic [1:0] PH_SECOND = 2'd2;

   // Configuration register indexes (byte address bits [3:2]).
   localparam int          CSR_ADDR_W     = 4;
   localparam logic [1:0] REG_URI_MODE   = 2'd0;
   localparam logic [1:0] REG_REDIRECT   = 2'd1;
   localparam logic [1:0] REG_NULL_FIX   = 2'd2;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHR_PERCENT  = 8'h25;
   localparam logic [7:0] CHR_QUESTION = 8'h3F;
   localparam logic [7:0] CHR_ZERO     = 8'h30;
   localparam logic [7:0] CHR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHR_CASE_BIT = 8'h20;
   localparam logic [7:0] CHR_DEL      = 8'h7F;
   localparam logic [3:0] DIGIT_LIMIT  = 4'd10;

   typedef struct packed {
      logic uri_mode;
      logic redirect_mode;
      logic null_fix_enable;
   } mode_type;

   // One decoded group: up to three bytes, byte_count 0 means a status-only result.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      byte_count;
      logic            last_byte;
      logic [15:0]     anomaly_count;
   } group_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Bit 4 set when the character is not a hex digit, else bits 3:0 give its value.
   function automatic logic [4:0] hex_value(input logic [7:0] ch);
      logic [7:0] low;
      low = ch | CHR_CASE_BIT;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         return {1'b0, ch[3:0]};
      end else if (low >= 8'h61 && low <= 8'h66) begin
         return {1'b0, 4'(low[3:0] + 4'd9)};
      end else begin
         return 5'h10;
      end
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= 8'h30 && ch <= 8'h39);
   endfunction

   // Rebuilds a first hex digit from its value, lowercase for letters.
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < DIGIT_LIMIT) begin
         return CHR_ZERO + {4'd0, v};
      end else begin
         return CHR_LOWER_A + {4'd0, 4'(v - DIGIT_LIMIT)};
      end
   endfunction

endpackage

>>> sv/url_percent_decoder.sv
// URL percent decoder: one encoded byte per item in, zero to three decoded bytes out.
// The first result of an item passes through the group queue and the response output register.
// Throughput: one item per cycle unless the queue is full; an item with two or three results
// holds the output register for each in turn, and the group queue of QueueDepth entries
// absorbs the difference. Synchronous active-high reset clears decode state, the queue,
// the output valid and the modes (uri_mode 0, redirect_mode 0, null_fix_enable 1).
module url_percent_decoder #(
   parameter int QueueDepth = url_dec_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,

   // Request stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] in_byte
   input  logic                               req_tlast,   // last_byte

   // Response stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [23:0]                        rsp_tdata,   // [7:0] out_byte, [23:8] anomaly_count
   output logic                               rsp_tlast,   // run_last
   output logic [1:0]                         rsp_tuser,   // [0] has_byte, [1] string_done

   // Configuration port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [url_dec_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   // The front end decodes each accepted byte in the cycle it arrives and writes
   // the whole group of resulting bytes into the queue as a single entry. The back
   // end walks each group into the output register one byte per cycle while rsp is ready.

   url_dec_pkg::mode_type         mode_ff, mode_in;
   url_dec_pkg::group_type         push_group;
   url_dec_pkg::group_type         head_group;
   url_dec_pkg::queue_status_type  queue_status;
   logic                           in_accept;
   logic                           push;
   logic                           pop;
   logic                           csr_write;
   logic                           has_byte;
   logic                           string_done;
   logic [7:0]                     out_byte;
   logic [15:0]                    anomaly_count;

   // Configuration registers. The user must make writes land only while the block is idle;
   // the block does not enforce this. The modes feed the decoder directly.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            url_dec_pkg::REG_URI_MODE: mode_in.uri_mode        = csr_pwdata[0];
            url_dec_pkg::REG_REDIRECT: mode_in.redirect_mode   = csr_pwdata[0];
            url_dec_pkg::REG_NULL_FIX: mode_in.null_fix_enable = csr_pwdata[0];
            default:                   mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '{uri_mode: 1'b0, redirect_mode: 1'b0, null_fix_enable: 1'b1};
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         url_dec_pkg::REG_URI_MODE: csr_prdata = {31'd0, mode_ff.uri_mode};
         url_dec_pkg::REG_REDIRECT: csr_prdata = {31'd0, mode_ff.redirect_mode};
         url_dec_pkg::REG_NULL_FIX: csr_prdata = {31'd0, mode_ff.null_fix_enable};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // The request side only waits when the queue is full; a stalled response
   // side does not block intake until the queue has filled up.
   assign req_tready = !queue_status.full;
   assign in_accept  = req_tvalid && req_tready;

   url_dec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .in_accept  (in_accept),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .push       (push),
      .push_group (push_group)
   );

   url_dec_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .head_group (head_group),
      .status     (queue_status)
   );

   url_dec_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_group      (head_group),
      .status          (queue_status),
      .pop             (pop),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_byte        (out_byte),
      .out_has_byte    (has_byte),
      .out_run_last    (rsp_tlast),
      .out_string_done (string_done),
      .out_anomaly     (anomaly_count)
   );

   assign rsp_tdata = {anomaly_count, out_byte};
   assign rsp_tuser = {string_done, has_byte};

endmodule

>>> sv/url_dec_front.sv
module url_dec_front (
   input  logic                    clock,
   input  logic                    reset,
   input  url_dec_pkg::mode_type   mode,
   input  logic                    in_accept,
   input  logic [7:0]              in_byte,
   input  logic                    in_last,
   output logic                    push,
   output url_dec_pkg::group_type  push_group
);

   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  high_ff, high_in;
   logic [7:0]  raw_ff, raw_in;
   logic        stop_ff, stop_in;
   logic [15:0] anom_ff, anom_in;

   logic [2:0][7:0] put_bytes;
   logic [2:0][7:0] fixed_bytes;
   logic [1:0]      put_count;
   logic [1:0]      null_count;
   logic            bad_escape;
   logic [4:0]      hv;
   logic [7:0]      dec;
   logic            letter;
   logic [16:0]     anom_sum;
   logic [15:0]     anom_step;

   always_comb begin
      hv         = url_dec_pkg::hex_value(in_byte);
      dec        = {high_ff, hv[3:0]};
      letter     = !url_dec_pkg::is_digit(in_byte);
      put_bytes  = '0;
      put_count  = 2'd0;
      bad_escape = 1'b0;
      phase_in   = phase_ff;
      high_in    = high_ff;
      raw_in     = raw_ff;
      stop_in    = stop_ff;
      if (!stop_ff) begin
         unique case (phase_ff)
            url_dec_pkg::PH_FIRST: begin
               if (!hv[4]) begin
                  high_in  = hv[3:0];
                  raw_in   = in_byte;
                  phase_in = url_dec_pkg::PH_SECOND;
               end else begin
                  bad_escape   = 1'b1;
                  phase_in     = url_dec_pkg::PH_USUAL;
                  put_bytes[0] = url_dec_pkg::CHR_PERCENT;
                  put_bytes[1] = in_byte;
                  put_count    = 2'd2;
               end
            end
            url_dec_pkg::PH_SECOND: begin
               phase_in = url_dec_pkg::PH_USUAL;
               if (hv[4]) begin
                  bad_escape   = 1'b1;
                  put_bytes[0] = url_dec_pkg::CHR_PERCENT;
                  put_bytes[1] = url_dec_pkg::hex_char(high_ff);
                  put_bytes[2] = in_byte;
                  put_count    = 2'd3;
               end else if (letter && mode.uri_mode) begin
                  put_bytes[0] = dec;
                  put_count    = 2'd1;
                  stop_in      = (dec == url_dec_pkg::CHR_QUESTION);
               end else if (mode.redirect_mode) begin
                  if (letter && dec == url_dec_pkg::CHR_QUESTION) begin
                     put_bytes[0] = dec;
                     put_count    = 2'd1;
                     stop_in      = 1'b1;
                  end else if (dec > url_dec_pkg::CHR_PERCENT && dec < url_dec_pkg::CHR_DEL) begin
                     put_bytes[0] = dec;
                     put_count    = 2'd1;
                  end else begin
                     put_bytes[0] = url_dec_pkg::CHR_PERCENT;
                     put_bytes[1] = raw_ff;
                     put_bytes[2] = in_byte;
                     put_count    = 2'd3;
                  end
               end else begin
                  put_bytes[0] = dec;
                  put_count    = 2'd1;
               end
            end
            default: begin
               // The unused phase code behaves as the usual phase.
               if (in_byte == url_dec_pkg::CHR_QUESTION
                   && (mode.uri_mode || mode.redirect_mode)) begin
                  put_bytes[0] = in_byte;
                  put_count    = 2'd1;
                  stop_in      = 1'b1;
               end else if (in_byte == url_dec_pkg::CHR_PERCENT) begin
                  phase_in = url_dec_pkg::PH_FIRST;
               end else begin
                  put_bytes[0] = in_byte;
                  put_count    = 2'd1;
               end
            end
         endcase
      end

      // Zero bytes that are really emitted turn into '0' and count as anomalies when null_fix_enable is set.
      null_count = 2'd0;
      for (int i = 0; i < 3; i++) begin
         fixed_bytes[i] = put_bytes[i];
         if (2'(i) < put_count && put_bytes[i] == 8'd0 && mode.null_fix_enable) begin
            fixed_bytes[i] = url_dec_pkg::CHR_ZERO;
            null_count     = null_count + 2'd1;
         end
      end

      anom_sum  = {1'b0, anom_ff} + {15'd0, null_count} + {16'd0, bad_escape};
      anom_step = anom_sum[16] ? 16'hFFFF : anom_sum[15:0];
      anom_in   = anom_step;

      if (in_last) begin
         phase_in = url_dec_pkg::PH_USUAL;
         high_in  = 4'd0;
         raw_in   = 8'd0;
         stop_in  = 1'b0;
         anom_in  = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= url_dec_pkg::PH_USUAL;
         high_ff  <= 4'd0;
         raw_ff   <= 8'd0;
         stop_ff  <= 1'b0;
         anom_ff  <= 16'd0;
      end else if (in_accept) begin
         phase_ff <= phase_in;
         high_ff  <= high_in;
         raw_ff   <= raw_in;
         stop_ff  <= stop_in;
         anom_ff  <= anom_in;
      end
   end

   assign push                     = in_accept && (put_count != 2'd0 || in_last);
   assign push_group.bytes         = fixed_bytes;
   assign push_group.byte_count    = put_count;
   assign push_group.last_byte     = in_last;
   assign push_group.anomaly_count = anom_step;

endmodule

>>> sv/url_dec_queue.sv
module url_dec_queue #(
   parameter int Depth = url_dec_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  url_dec_pkg::group_type          push_group,
   input  logic                            pop,
   output url_dec_pkg::group_type          head_group,
   output url_dec_pkg::queue_status_type   status
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   url_dec_pkg::group_type entry_ff [Depth];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;

   // Pointers wrap back to zero after the last entry, so any depth works.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(Depth - 1)) ? '0 : AW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(Depth - 1)) ? '0 : AW'(rd_ptr_ff + 1'b1);
      end
      count_in  = count_ff + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

   assign head_group   = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (AW+1)'(Depth));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("queue read while empty");

endmodule

>>> sv/url_dec_back.sv
module url_dec_back (
   input  logic                            clock,
   input  logic                            reset,
   input  url_dec_pkg::group_type          head_group,
   input  url_dec_pkg::queue_status_type   status,
   output logic                            pop,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [7:0]                      out_byte,
   output logic                            out_has_byte,
   output logic                            out_run_last,
   output logic                            out_string_done,
   output logic [15:0]                     out_anomaly
);

   logic        valid_ff, valid_in;
   logic [1:0]  index_ff, index_in;
   logic [7:0]  byte_ff;
   logic        has_ff;
   logic        run_last_ff;
   logic        done_ff;
   logic [15:0] anom_ff;

   logic [1:0]  result_count;
   logic        final_result;
   logic        load;
   logic [7:0]  sel_byte;

   always_comb begin
      result_count = (head_group.byte_count == 2'd0) ? 2'd1 : head_group.byte_count;
      final_result = (index_ff == 2'(result_count - 2'd1));
      load         = !status.empty && (!valid_ff || out_ready);
      pop          = load && final_result;
      valid_in     = load || (valid_ff && !out_ready);
      if (!load) begin
         index_in = index_ff;
      end else if (final_result) begin
         index_in = 2'd0;
      end else begin
         index_in = 2'(index_ff + 2'd1);
      end
      case (index_ff)
         2'd0:    sel_byte = head_group.bytes[0];
         2'd1:    sel_byte = head_group.bytes[1];
         default: sel_byte = head_group.bytes[2];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff     <= (head_group.byte_count == 2'd0) ? 8'd0 : sel_byte;
         has_ff      <= (head_group.byte_count != 2'd0);
         run_last_ff <= final_result;
         done_ff     <= final_result && head_group.last_byte;
         anom_ff     <= (final_result && head_group.last_byte) ?
                        head_group.anomaly_count : 16'd0;
      end
   end

   assign out_valid       = valid_ff;
   assign out_byte        = byte_ff;
   assign out_has_byte    = has_ff;
   assign out_run_last    = run_last_ff;
   assign out_string_done = done_ff;
   assign out_anomaly     = anom_ff;

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_string_done |-> out_run_last)
      else $error("string end on a result that does not end its item");

   a_count_only_at_end: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_string_done |-> out_anomaly == 16'd0)
      else $error("anomaly count shown before the string end");

   a_index_in_group: assert property (@(posedge clock) disable iff (reset)
      !status.empty |-> index_ff <= 2'(result_count - 2'd1))
      else $error("result index past the end of its group");

endmodule

>>> tb/sv/tb_url_percent_decoder.sv
// Testbench for the URL percent decoder.
//
// Encoded bytes go in on the req stream. Every accepted item runs through a local model of
// the decoder, and the bytes it predicts, or a typed row's own, wait in a queue. Each rsp
// item is checked field by field against the oldest entry of that queue. The modes are
// written over the APB-style port only while the block is idle, each read back after its write.
module tb_url_percent_decoder;

   localparam int CYCLE_LIMIT    = 20000;
   localparam int DRAIN_CYCLES   = 8;      // the output register plus the group queue
   localparam int HOLD_CYCLES    = 80;
   localparam int SEND_GAP_PCT   = 15;     // chance of a gap after an item, 15 in 100
   localparam int RECV_STALL_PCT = 18;
   localparam int PHASE_ITEMS    = 15;
   localparam int NUM_ROWS       = 27;

   // Index 3 has no register behind it, so a write there must change nothing.
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef enum logic {ROW_ITEM, ROW_MODE} row_kind_type;

   // One row of the directed table. A typed row carries its expected bytes and anomaly
   // count. An untyped row is checked against the model alone.
   typedef struct packed {
      row_kind_type          kind;
      logic [7:0]            data;
      logic                  last;
      logic                  typed;
      logic [1:0]            n_bytes;
      logic [2:0][7:0]       bytes;
      logic [15:0]           anom;
      url_dec_pkg::mode_type modes;
   } stim_row_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        has_byte;
      logic        run_last;
      logic        string_done;
      logic [15:0] anomaly_count;
   } dec_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [url_dec_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]                        csr_pwdata = 32'h0;
   logic [31:0]                        csr_prdata;
   logic                               csr_pready;

   url_percent_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // The model's copy of the modes and of the per-string decode state.
   logic       m_uri = 1'b0;
   logic       m_redirect = 1'b0;
   logic       m_null_fix = 1'b1;
   logic [1:0] p_phase = url_dec_pkg::PH_USUAL;
   logic [3:0] p_nibble = 4'h0;
   logic [7:0] p_first_raw = 8'h00;
   logic       p_halted = 1'b0;
   logic [15:0] p_anomaly = 16'h0;

   // Bytes emitted by the item that was just modeled.
   logic [2:0][7:0] emit_bytes;
   int              emit_n;
   logic [15:0]     anomaly_snap;

   dec_result_type decoded_q[$];
   dec_result_type want_r;

   int  errors = 0;
   int  cycle_cnt = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  mode_writes = 0;
   bit  idle_on = 1'b1;
   bit  hold_req = 1'b0;
   int  hold_left = 0;

   stim_row_type          dir_rows [0:NUM_ROWS-1];
   url_dec_pkg::mode_type phase_modes [0:5] =
      '{3'b001, 3'b101, 3'b010, 3'b111, 3'b000, 3'b110};

   initial begin
      forever #5 clock = ~clock;
   end

   // A run that hangs anywhere ends here.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles, %0d results still due",
                  $time, cycle_cnt, decoded_q.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Value of a hex digit in bits 3:0, or bit 4 set when the character is not one.
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | url_dec_pkg::CHR_CASE_BIT;
      if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
      if (folded >= "a" && folded <= "f") return {1'b0, 4'(folded - "a" + 8'd10)};
      return 5'h10;
   endfunction

   function automatic void bump_anomaly();
      if (p_anomaly != 16'hFFFF) p_anomaly = p_anomaly + 16'd1;
   endfunction

   // Emitting a zero byte with the null fix on turns it into '0' and counts an anomaly.
   function automatic void emit(input logic [7:0] b);
      logic [7:0] v;
      v = b;
      if (v == 8'h00 && m_null_fix) begin
         v = url_dec_pkg::CHR_ZERO;
         bump_anomaly();
      end
      if (emit_n < 3) begin
         emit_bytes[emit_n] = v;
         emit_n++;
      end
   endfunction

   // Runs one input byte through the model and leaves its output in emit_bytes.
   task automatic decode_step(input logic [7:0] ch, input logic last);
      logic [4:0] v;
      logic [7:0] dec;
      logic       letter;
      emit_n = 0;
      emit_bytes = '0;
      if (!p_halted) begin
         case (p_phase)
            url_dec_pkg::PH_FIRST: begin
               v = nibble_of(ch);
               if (!v[4]) begin
                  p_nibble = v[3:0];
                  p_first_raw = ch;
                  p_phase = url_dec_pkg::PH_SECOND;
               end else begin
                  // A bad first digit gives back the percent sign and the raw byte.
                  bump_anomaly();
                  p_phase = url_dec_pkg::PH_USUAL;
                  emit(url_dec_pkg::CHR_PERCENT);
                  emit(ch);
               end
            end
            url_dec_pkg::PH_SECOND: begin
               p_phase = url_dec_pkg::PH_USUAL;
               v = nibble_of(ch);
               if (v[4]) begin
                  // A bad second digit rebuilds the first digit, lowercase for letters.
                  emit(url_dec_pkg::CHR_PERCENT);
                  emit((p_nibble < 4'd10)
                       ? url_dec_pkg::CHR_ZERO + {4'd0, p_nibble}
                       : url_dec_pkg::CHR_LOWER_A + {4'd0, p_nibble} - 8'd10);
                  emit(ch);
                  bump_anomaly();
               end else begin
                  dec = {p_nibble, v[3:0]};
                  letter = !(ch >= "0" && ch <= "9");
                  if (letter && m_uri) begin
                     emit(dec);
                     if (dec == url_dec_pkg::CHR_QUESTION) p_halted = 1'b1;
                  end else if (m_redirect) begin
                     if (letter && dec == url_dec_pkg::CHR_QUESTION) begin
                        emit(dec);
                        p_halted = 1'b1;
                     end else if (dec > url_dec_pkg::CHR_PERCENT
                                  && dec < url_dec_pkg::CHR_DEL) begin
                        emit(dec);
                     end else begin
                        emit(url_dec_pkg::CHR_PERCENT);
                        emit(p_first_raw);
                        emit(ch);
                     end
                  end else begin
                     emit(dec);
                  end
               end
            end
            default: begin
               if (ch == url_dec_pkg::CHR_QUESTION && (m_uri || m_redirect)) begin
                  emit(ch);
                  p_halted = 1'b1;
               end else if (ch == url_dec_pkg::CHR_PERCENT) begin
                  p_phase = url_dec_pkg::PH_FIRST;
               end else begin
                  emit(ch);
               end
            end
         endcase
      end
      anomaly_snap = p_anomaly;
      if (last) begin
         p_phase = url_dec_pkg::PH_USUAL;
         p_nibble = 4'h0;
         p_first_raw = 8'h00;
         p_halted = 1'b0;
         p_anomaly = 16'h0;
      end
   endtask

   // Turns the bytes of one item into result items. The last byte of a string always
   // yields at least a status-only item, and the string's final item carries the anomaly count.
   task automatic queue_results(input logic [2:0][7:0] bytes, input int n, input logic last,
                                input logic [15:0] anom);
      dec_result_type r;
      int             total;
      int             k;
      total = (last && n == 0) ? 1 : n;
      for (k = 0; k < total; k++) begin
         r.out_byte = (k < n) ? bytes[k] : 8'h00;
         r.has_byte = (k < n);
         r.run_last = (k == total - 1);
         r.string_done = last && (k == total - 1);
         r.anomaly_count = (last && k == total - 1) ? anom : 16'h0;
         decoded_q.push_back(r);
      end
   endtask

   function automatic stim_row_type row_item(input logic [7:0] d, input logic l);
      stim_row_type r;
      r = '0;
      r.kind = ROW_ITEM;
      r.data = d;
      r.last = l;
      return r;
   endfunction

   function automatic stim_row_type row_typed(input logic [7:0] d, input logic l,
                                              input logic [1:0] n, input logic [7:0] b0,
                                              input logic [7:0] b1, input logic [7:0] b2,
                                              input logic [15:0] a);
      stim_row_type r;
      r = row_item(d, l);
      r.typed = 1'b1;
      r.n_bytes = n;
      r.bytes = {b2, b1, b0};
      r.anom = a;
      return r;
   endfunction

   function automatic stim_row_type row_mode(input url_dec_pkg::mode_type md);
      stim_row_type r;
      r = '0;
      r.kind = ROW_MODE;
      r.modes = md;
      return r;
   endfunction

   function automatic logic [7:0] rand_hex_char();
      logic [3:0] v;
      v = 4'($urandom_range(15));
      if (v < 4'd10) return "0" + {4'd0, v};
      return ($urandom_range(1) ? "a" : "A") + {4'd0, v} - 8'd10;
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] c;
      logic [4:0] v;
      do begin
         c = 8'($urandom_range(255));
         v = nibble_of(c);
      end while (!v[4]);
      return c;
   endfunction

   // Offers one item and holds it until it is taken. The model runs at the accepting edge.
   // A gap may follow, but valid is never lowered and raised in the same time step.
   task automatic push_item(input stim_row_type row);
      req_tdata <= row.data;
      req_tlast <= row.last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      decode_step(row.data, row.last);
      if (row.typed) queue_results(row.bytes, row.n_bytes, row.last, row.anom);
      else queue_results(emit_bytes, emit_n, row.last, anomaly_snap);
      items_sent++;
      if (idle_on && $urandom_range(99) < SEND_GAP_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   // One register write, then, unless the index is unused, a read back of the same register.
   // The model takes the new value at the write. The port rests before the next transfer.
   task automatic set_mode(input logic [1:0] idx, input logic v);
      logic [31:0] w;
      w = $urandom();
      w[0] = v;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= w;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         url_dec_pkg::REG_URI_MODE: m_uri = v;
         url_dec_pkg::REG_REDIRECT: m_redirect = v;
         url_dec_pkg::REG_NULL_FIX: m_null_fix = v;
         default: ;
      endcase
      mode_writes++;
      if (idx != REG_UNUSED) begin
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (csr_pready !== 1'b1);
         if (csr_prdata[0] !== v) begin
            errors++;
            $display("%0t: register %0d read back expected %0h, actual %0h",
                     $time, idx, v, csr_prdata[0]);
         end
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // The modes change only once every expected result has arrived and the last items,
   // even those that produce no result, have had time to leave the block.
   task automatic apply_modes(input url_dec_pkg::mode_type md);
      req_tvalid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      set_mode(url_dec_pkg::REG_URI_MODE, md.uri_mode);
      set_mode(url_dec_pkg::REG_REDIRECT, md.redirect_mode);
      set_mode(url_dec_pkg::REG_NULL_FIX, md.null_fix_enable);
      set_mode(REG_UNUSED, 1'($urandom_range(1)));
   endtask

   // A random string: many well-formed escapes with random digits, some of them the
   // escape for '?', mixed with broken escapes, plain '?', zero bytes and raw noise.
   // Now and then the string ends with an open escape.
   task automatic send_random_string();
      logic [7:0] s[$];
      int         len;
      int         k;
      int         r;
      len = $urandom_range(1, 8);
      for (k = 0; k < len; k++) begin
         r = $urandom_range(99);
         if (r < 8) begin
            s.push_back(url_dec_pkg::CHR_PERCENT);
            s.push_back("3");
            s.push_back($urandom_range(1) ? "F" : "f");
         end else if (r < 45) begin
            s.push_back(url_dec_pkg::CHR_PERCENT);
            s.push_back(rand_hex_char());
            s.push_back(rand_hex_char());
         end else if (r < 53) begin
            s.push_back(url_dec_pkg::CHR_PERCENT);
            s.push_back(rand_non_hex());
         end else if (r < 60) begin
            s.push_back(url_dec_pkg::CHR_PERCENT);
            s.push_back(rand_hex_char());
            s.push_back(rand_non_hex());
         end else if (r < 68) begin
            s.push_back(url_dec_pkg::CHR_QUESTION);
         end else if (r < 74) begin
            s.push_back(8'h00);
         end else begin
            s.push_back(8'($urandom_range(255)));
         end
      end
      if ($urandom_range(9) == 0) s.push_back(url_dec_pkg::CHR_PERCENT);
      if ($urandom_range(9) == 0) s.push_back(rand_hex_char());
      for (k = 0; k < s.size(); k++) push_item(row_item(s[k], k == s.size() - 1));
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // The receiver is ready most cycles. On request it holds off for a long stretch, which
   // it counts itself, so that the block backs up into its input.
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_on && $urandom_range(99) < RECV_STALL_PCT);
      end
   end

   // Every result item taken is compared with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         results_seen++;
         if (decoded_q.size() == 0) begin
            errors++;
            $display("%0t: result item with none expected, expected nothing, actual %h/%b/%b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want_r = decoded_q.pop_front();
            check_field("out_byte", 16'(want_r.out_byte), 16'(rsp_tdata[7:0]));
            check_field("has_byte", 16'(want_r.has_byte), 16'(rsp_tuser[0]));
            check_field("run_last", 16'(want_r.run_last), 16'(rsp_tlast));
            check_field("string_done", 16'(want_r.string_done), 16'(rsp_tuser[1]));
            check_field("anomaly_count", want_r.anomaly_count, rsp_tdata[23:8]);
         end
      end
   end

   initial begin : main
      int k;
      int p;
      int target;

      // The directed table opens with the reset modes, then turns to uri mode and then to
      // redirect mode. Typed rows give their result outright.
      dir_rows = '{
         row_typed("A",   1'b1, 2'd1, "A",   8'h00, 8'h00, 16'd0),
         row_typed(8'h00, 1'b1, 2'd1, "0",   8'h00, 8'h00, 16'd1),
         row_typed(8'hFF, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00, 16'd0),
         row_typed("%",   1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 16'd0),
         row_typed("G",   1'b1, 2'd2, "%",   "G",   8'h00, 16'd1),
         row_typed("%",   1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 16'd0),
         row_typed("4",   1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 16'd0),
         row_typed("z",   1'b1, 2'd3, "%",   "4",   "z",   16'd1),
         row_typed("%",   1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 16'd0),
         row_typed("B",   1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 16'd0),
         row_mode(3'b100),
         row_item(8'h00, 1'b0),
         row_item("%", 1'b0),
         row_item("3", 1'b0),
         row_item("3", 1'b0),
         row_item("%", 1'b0),
         row_item("3", 1'b0),
         row_item("F", 1'b0),
         row_item("x", 1'b1),
         row_item("?", 1'b1),
         row_mode(3'b011),
         row_item("%", 1'b0),
         row_item("0", 1'b0),
         row_item("1", 1'b1),
         row_item("%", 1'b0),
         row_item("3", 1'b0),
         row_item("f", 1'b1)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < NUM_ROWS; k++) begin
         if (dir_rows[k].kind == ROW_MODE) apply_modes(dir_rows[k].modes);
         else push_item(dir_rows[k]);
      end

      // Random strings under each mode setting. The third phase runs without idling and
      // the fourth starts with a long receiver hold-off.
      for (p = 0; p < 6; p++) begin
         apply_modes(phase_modes[p]);
         idle_on = (p != 2);
         if (p == 3) hold_req = 1'b1;
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) send_random_string();
      end

      req_tvalid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items and checked %0d result items over %0d register writes,",
               items_sent, results_seen, mode_writes);
      $display("across every mode mix, a long receiver stall and a gap-free stretch; %0d mismatches.",
               errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
